### src/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants for the sprite mask collision block: item
// opcodes, controller states, luminance weights and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package smc_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_WR_A  = 2'd0,
    OP_WR_B  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_GEO1,
    ST_GEO2,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // Register indexes, decoded from paddr[2]
  typedef enum logic {
    REG_ALPHA_THR = 1'b0,
    REG_LUMA_THR  = 1'b1
  } reg_idx_t;

  localparam logic [7:0] ALPHA_THR_RST = 8'd200;
  localparam logic [8:0] LUMA_THR_RST  = 9'd205;

  // Luminance weights, scaled by LUMA_SCALE
  localparam int unsigned LUMA_WR    = 299;
  localparam int unsigned LUMA_WG    = 587;
  localparam int unsigned LUMA_WB    = 114;
  localparam int unsigned LUMA_SCALE = 1000;
  localparam int unsigned LUM_W      = 19;

  // Controller to datapath
  typedef struct packed {
    logic clr;       // clear one mask row
    logic capture;   // take the input item
    logic ld_rd;     // read the target row, weigh the pixel
    logic ld_wr;     // write back the modified row
    logic geo1;      // rectangle ends and overlap start
    logic geo2;      // overlap size, shifts and start rows
    logic scan;      // issue one overlap row
    logic load_out;  // move the result into the output register
  } smc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic ovl;
    logic scan_last;
    logic out_busy;
  } smc_sts_t;

endpackage

### src/smc_mask_ram.sv
// ----------------------------------------------------------------------------
// smc_mask_ram
// Single-port mask memory, one row per address, registered read data.
// ----------------------------------------------------------------------------
module smc_mask_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one row, read the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

### src/smc_datapath.sv
// ----------------------------------------------------------------------------
// smc_datapath
// Item capture, pixel solidity test, rectangle intersection, row scan with
// shift-and-AND over both mask memories, and the output register.
// ----------------------------------------------------------------------------
module smc_datapath
  import smc_pkg::*;
#(
  parameter int SPRITE_W = 64,
  parameter int SPRITE_H = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  smc_cmd_t           cmd,
  output smc_sts_t           sts,
  input  logic [7:0]         alpha_thr,
  input  logic [8:0]         luma_thr,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_pix_x,
  input  logic [5:0]         in_pix_y,
  input  logic [31:0]        in_rgba,
  input  logic signed [11:0] in_a_x,
  input  logic signed [11:0] in_a_y,
  input  logic [6:0]         in_a_w,
  input  logic [6:0]         in_a_h,
  input  logic signed [11:0] in_b_x,
  input  logic signed [11:0] in_b_y,
  input  logic [6:0]         in_b_w,
  input  logic [6:0]         in_b_h,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_overlap_found,
  output logic               out_collided
);

  localparam int RW = (SPRITE_H > 1) ? $clog2(SPRITE_H) : 1;
  localparam int HW = $clog2(SPRITE_H + 1);
  localparam int CW = (SPRITE_W > 1) ? $clog2(SPRITE_W) : 1;

  // Captured item
  op_t                op_r;
  logic [5:0]         px_r, py_r;
  logic [31:0]        rgba_r;
  logic signed [11:0] ax_r, ay_r, bx_r, by_r;
  logic [6:0]         aw_r, ah_r, bw_r, bh_r;

  // Pixel weighing
  logic [LUM_W-1:0] lum_r, lum_nxt;
  logic             alpha_ok_r;
  logic             solid;
  logic             pix_ok;
  logic [SPRITE_W-1:0] row_wr;

  // Geometry
  logic [6:0]         awc, ahc, bwc, bhc;
  logic signed [13:0] ax14, ay14, bx14, by14;
  logic signed [13:0] ae_nxt, be_nxt, aye_nxt, bye_nxt;
  logic signed [13:0] ae_r, be_r, aye_r, bye_r, x0_r, y0_r;
  logic               empty_r;
  logic signed [13:0] x1, y1;
  logic               ovl_nxt, ovl_r;
  logic [CW-1:0]      sa_r, sb_r;
  logic [6:0]         ow_r;
  logic [RW-1:0]      ra_r, rb_r;
  logic [HW-1:0]      oh_r;

  // Scan
  logic [HW-1:0]       rc_r;
  logic                rd_v_r;
  logic                hit_r;
  logic [SPRITE_W-1:0] a_sh, b_sh, ow_msk;
  logic                row_hit;

  // Memories
  logic                we_a, we_b;
  logic [RW-1:0]       addr_a, addr_b;
  logic [SPRITE_W-1:0] wdata;
  logic [SPRITE_W-1:0] arow_q, brow_q;

  // Output register
  logic out_valid_r, ovl_out_r, col_out_r;

  function automatic logic in_range_w(input logic [6:0] w);
    in_range_w = (w <= 7'(SPRITE_W));
  endfunction

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_op);
      px_r   <= in_pix_x;
      py_r   <= in_pix_y;
      rgba_r <= in_rgba;
      ax_r   <= in_a_x;
      ay_r   <= in_a_y;
      aw_r   <= in_a_w;
      ah_r   <= in_a_h;
      bx_r   <= in_b_x;
      by_r   <= in_b_y;
      bw_r   <= in_b_w;
      bh_r   <= in_b_h;
    end
  end

  // Weigh the pixel: luminance sum and alpha test
  assign lum_nxt = LUM_W'(LUMA_WR * rgba_r[31:24]) + LUM_W'(LUMA_WG * rgba_r[23:16])
                 + LUM_W'(LUMA_WB * rgba_r[15:8]);

  always_ff @(posedge clk) begin
    if (cmd.ld_rd) begin
      lum_r      <= lum_nxt;
      alpha_ok_r <= (rgba_r[7:0] >= alpha_thr);
    end
  end

  assign solid  = alpha_ok_r && (lum_r < LUM_W'(LUMA_SCALE * luma_thr));
  assign pix_ok = (11'(py_r) < 11'(SPRITE_H)) && (7'(px_r) < 7'(SPRITE_W));

  // Modify one bit of the row read back
  always_comb begin
    row_wr = (op_r == OP_WR_A) ? arow_q : brow_q;
    if (pix_ok) begin
      row_wr[CW'(px_r)] = solid;
    end
  end

  // Clamp sizes and widen positions
  assign awc  = (in_range_w(aw_r)) ? aw_r : 7'(SPRITE_W);
  assign bwc  = (in_range_w(bw_r)) ? bw_r : 7'(SPRITE_W);
  assign ahc  = (11'(ah_r) > 11'(SPRITE_H)) ? 7'(SPRITE_H) : ah_r;
  assign bhc  = (11'(bh_r) > 11'(SPRITE_H)) ? 7'(SPRITE_H) : bh_r;
  assign ax14 = 14'(ax_r);
  assign ay14 = 14'(ay_r);
  assign bx14 = 14'(bx_r);
  assign by14 = 14'(by_r);

  assign ae_nxt  = ax14 + 14'(awc);
  assign be_nxt  = bx14 + 14'(bwc);
  assign aye_nxt = ay14 + 14'(ahc);
  assign bye_nxt = by14 + 14'(bhc);

  // First geometry step: rectangle ends and overlap start
  always_ff @(posedge clk) begin
    if (cmd.geo1) begin
      ae_r    <= ae_nxt;
      be_r    <= be_nxt;
      aye_r   <= aye_nxt;
      bye_r   <= bye_nxt;
      x0_r    <= (ax14 > bx14) ? ax14 : bx14;
      y0_r    <= (ay14 > by14) ? ay14 : by14;
      empty_r <= (awc == 7'd0) || (ahc == 7'd0) || (bwc == 7'd0) || (bhc == 7'd0);
    end
  end

  // Second geometry step: overlap end, size, shifts and start rows
  assign x1      = (ae_r < be_r) ? ae_r : be_r;
  assign y1      = (aye_r < bye_r) ? aye_r : bye_r;
  assign ovl_nxt = !empty_r && (x1 > x0_r) && (y1 > y0_r);

  always_ff @(posedge clk) begin
    if (cmd.geo2) begin
      sa_r <= CW'(x0_r - ax14);
      sb_r <= CW'(x0_r - bx14);
      ow_r <= 7'(x1 - x0_r);
      ra_r <= RW'(y0_r - ay14);
      rb_r <= RW'(y0_r - by14);
      oh_r <= HW'(y1 - y0_r);
    end
  end

  // Overlap flag: cleared per item, set by the check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_r <= 1'b0;
    end else if (cmd.capture) begin
      ovl_r <= 1'b0;
    end else if (cmd.geo2) begin
      ovl_r <= ovl_nxt;
    end
  end

  // Row counter for the clearing pass and the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= '0;
    end else if (cmd.capture) begin
      rc_r <= '0;
    end else if (cmd.clr || cmd.scan) begin
      rc_r <= rc_r + HW'(1);
    end
  end

  // Memory port control
  always_comb begin
    we_a   = 1'b0;
    we_b   = 1'b0;
    addr_a = RW'(py_r);
    addr_b = RW'(py_r);
    wdata  = row_wr;
    priority if (cmd.clr) begin
      we_a   = 1'b1;
      we_b   = 1'b1;
      addr_a = RW'(rc_r);
      addr_b = RW'(rc_r);
      wdata  = '0;
    end else if (cmd.scan) begin
      addr_a = ra_r + RW'(rc_r);
      addr_b = rb_r + RW'(rc_r);
    end else if (cmd.ld_wr) begin
      we_a = pix_ok && (op_r == OP_WR_A);
      we_b = pix_ok && (op_r == OP_WR_B);
    end else begin
      we_a = 1'b0;
    end
  end

  smc_mask_ram #(
    .DEPTH (SPRITE_H),
    .WIDTH (SPRITE_W),
    .AW    (RW)
  ) u_mask_a (
    .clk   (clk),
    .we    (we_a),
    .addr  (addr_a),
    .wdata (wdata),
    .rdata (arow_q)
  );

  smc_mask_ram #(
    .DEPTH (SPRITE_H),
    .WIDTH (SPRITE_W),
    .AW    (RW)
  ) u_mask_b (
    .clk   (clk),
    .we    (we_b),
    .addr  (addr_b),
    .wdata (wdata),
    .rdata (brow_q)
  );

  // Align both rows to the overlap start and AND them
  always_comb begin
    a_sh = arow_q >> sa_r;
    b_sh = brow_q >> sb_r;
    for (int k = 0; k < SPRITE_W; k++) begin
      ow_msk[k] = (7'(k) < ow_r);
    end
    row_hit = |(a_sh & b_sh & ow_msk);
  end

  // Accumulate the hit one row behind the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      rd_v_r <= cmd.scan;
      if (cmd.capture) begin
        hit_r <= 1'b0;
      end else if (rd_v_r) begin
        hit_r <= hit_r | row_hit;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ovl_out_r <= ovl_r;
      col_out_r <= hit_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_overlap_found = ovl_out_r;
  assign out_collided      = col_out_r;

  // Status to the controller
  assign sts.clr_last  = (rc_r == HW'(SPRITE_H - 1));
  assign sts.ovl       = ovl_nxt;
  assign sts.scan_last = (rc_r == oh_r - HW'(1));
  assign sts.out_busy  = out_valid_r && out_stall;

endmodule

### src/smc_ctrl.sv
// ----------------------------------------------------------------------------
// smc_ctrl
// Sequencer: clearing pass after reset, then one item at a time through the
// load, geometry and scan steps, and the hand-off to the output register.
// ----------------------------------------------------------------------------
module smc_ctrl
  import smc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  output smc_cmd_t   cmd,
  input  smc_sts_t   sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_WR_A, OP_WR_B: state_nxt = ST_LD_RD;
            OP_CHECK:         state_nxt = ST_GEO1;
            OP_NONE:          state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_LD_RD:  state_nxt = ST_LD_WR;
      ST_LD_WR:  state_nxt = ST_RESULT;
      ST_GEO1:   state_nxt = ST_GEO2;
      ST_GEO2:   state_nxt = sts.ovl ? ST_SCAN : ST_RESULT;
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR:  cmd.clr = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LD_RD:  cmd.ld_rd = 1'b1;
      ST_LD_WR:  cmd.ld_wr = 1'b1;
      ST_GEO1:   cmd.geo1 = 1'b1;
      ST_GEO2:   cmd.geo2 = 1'b1;
      ST_SCAN:   cmd.scan = 1'b1;
      ST_DRAIN:  cmd = '0;
      ST_RESULT: cmd.load_out = !sts.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

### src/sprite_mask_collision.sv
// One item at a time: in_stall stays high from an accept until the result
// is loaded, and a stalled output holds the next one back. A check with
// overlap scans its H overlap rows (H up to SPRITE_H); the scan reads one
// row of each mask memory per cycle, so checks are bound by the overlap
// height. Reset (synchronous, active low) starts a clearing pass over all
// SPRITE_H rows that zeroes both masks; in_stall stays high until it ends.
// ----------------------------------------------------------------------------
// sprite_mask_collision
// Pixel-exact collision between two sprite masks loaded pixel by pixel, with
// an APB-style register port for the solidity thresholds.
// ----------------------------------------------------------------------------
module sprite_mask_collision
  import smc_pkg::*;
#(
  parameter int SPRITE_W = 64,
  parameter int SPRITE_H = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_pix_x,
  input  logic [5:0]         in_pix_y,
  input  logic [31:0]        in_rgba,
  input  logic signed [11:0] in_a_x,
  input  logic signed [11:0] in_a_y,
  input  logic [6:0]         in_a_w,
  input  logic [6:0]         in_a_h,
  input  logic signed [11:0] in_b_x,
  input  logic signed [11:0] in_b_y,
  input  logic [6:0]         in_b_w,
  input  logic [6:0]         in_b_h,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_overlap_found,
  output logic               out_collided,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  smc_cmd_t   cmd;
  smc_sts_t   sts;
  logic [7:0] alpha_thr_r;
  logic [8:0] luma_thr_r;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_thr_r <= ALPHA_THR_RST;
      luma_thr_r  <= LUMA_THR_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_ALPHA_THR: alpha_thr_r <= pwdata[7:0];
        REG_LUMA_THR:  luma_thr_r  <= pwdata[8:0];
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_ALPHA_THR: prdata = 32'(alpha_thr_r);
      REG_LUMA_THR:  prdata = 32'(luma_thr_r);
    endcase
  end

  assign pready = 1'b1;

  smc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  smc_datapath #(
    .SPRITE_W (SPRITE_W),
    .SPRITE_H (SPRITE_H)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .alpha_thr         (alpha_thr_r),
    .luma_thr          (luma_thr_r),
    .in_op             (in_op),
    .in_pix_x          (in_pix_x),
    .in_pix_y          (in_pix_y),
    .in_rgba           (in_rgba),
    .in_a_x            (in_a_x),
    .in_a_y            (in_a_y),
    .in_a_w            (in_a_w),
    .in_a_h            (in_a_h),
    .in_b_x            (in_b_x),
    .in_b_y            (in_b_y),
    .in_b_w            (in_b_w),
    .in_b_h            (in_b_h),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_overlap_found (out_overlap_found),
    .out_collided      (out_collided)
  );

endmodule

### src/smc_checker.sv
// ----------------------------------------------------------------------------
// smc_checker
// Port-level checks for the sprite mask collision block, bound to the top.
// ----------------------------------------------------------------------------
module smc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_overlap_found,
  input logic out_collided
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_overlap_found)
                               && $stable(out_collided))
    else $error("stalled result changed");

  // A collision implies an overlap
  a_col_ovl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overlap_found || !out_collided))
    else $error("collision reported without overlap");

  // One item at a time: stall right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // Reset drops results and starts the clearing pass
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("reset did not clear output or stall input");

endmodule

bind sprite_mask_collision smc_checker u_smc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_overlap_found (out_overlap_found),
  .out_collided      (out_collided)
);
